>>> hdl/pcdc_pkg.sv
// types and constants for the pid controller with dynamic integrator clamping
// used by pid_controller_dynamic_clamp_top; no other dependencies
package pcdc_pkg;

	localparam int GAIN_W = 16;
	localparam int PERIOD_W = 16;
	localparam int INT_W = 40;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd5;

	localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd256;
	localparam logic [PERIOD_W-1:0] PERIOD_ONE = 16'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_LIMIT,
		ST_INTEG,
		ST_MUL_D,
		ST_DIV,
		ST_SUM,
		ST_OUT
	} state_t;

endpackage

>>> hdl/pid_controller_dynamic_clamp_top.sv
// pid controller with dynamic integrator clamping, one shared multiplier and divider
// depends on pcdc_pkg
//
// usage:
//   s_* input stream, one beat per sample: setpoint in the low DATA_WIDTH bits of
//   s_tdata, measurement above it. m_* output stream, one beat per sample with the
//   drive value in the low bits of m_tdata. cfg_* writes one gain or limit register
//   per beat (index 0 kp, 1 ki, 2 kd, 3 out_min, 4 out_max, 5 sample_period);
//   cfg_ready is always high; the user must keep writes to idle, the block does not.
// timing:
//   a sample runs from its input beat to its output beat through the p and i products
//   on the shared 16 x (DATA_WIDTH + 2)-bit multiplier, limit and integrator update,
//   the d product, then the restoring divider for the derivative term at one quotient
//   bit per cycle over DATA_WIDTH + 18 bits, sum and output clamp.
//   s_tready is high only in idle, so one sample is in work at a time; the next
//   sample may enter while the previous output beat still waits on m_tready.
//   a stalled receiver holds the finished result, and the block then waits before
//   loading the next result into the output register.
// reset:
//   arst_n clears the integrator, the previous error and measurement, the output
//   valid and loads the register defaults (kp 1.0, ki 0, kd 0, full output range,
//   sample_period 1).
module pid_controller_dynamic_clamp_top #(
	parameter int DATA_WIDTH = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// setpoint, measurement
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// drive
	output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pcdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [((DATA_WIDTH > 16) ? DATA_WIDTH : 16)-1:0] cfg_data
);

	localparam int GW = pcdc_pkg::GAIN_W;
	localparam int PERW = pcdc_pkg::PERIOD_W;
	localparam int IW = pcdc_pkg::INT_W;
	localparam int EW = DATA_WIDTH + 1;
	localparam int BW = DATA_WIDTH + 2;
	localparam int PW = GW + BW;
	localparam int LW = PW + 1;
	localparam int CW = ((IW > LW) ? IW : LW) + 1;
	localparam int SW = CW + 2;
	localparam int CNT_W = $clog2(PW + 1);

	localparam logic signed [CW-1:0] INT_MAX_C = {{(CW-IW+1){1'b0}}, {(IW-1){1'b1}}};
	localparam logic signed [CW-1:0] INT_MIN_C = ~INT_MAX_C;

	pcdc_pkg::state_t state_q, state_d;

	logic signed [GW-1:0] kp_q, ki_q, kd_q;
	logic signed [DATA_WIDTH-1:0] out_min_q, out_max_q;
	logic [PERW-1:0] period_q;

	logic signed [IW-1:0] integ_q;
	logic signed [EW-1:0] prev_error_q;
	logic signed [DATA_WIDTH-1:0] prev_meas_q;

	logic signed [EW-1:0] err_q, dmeas_q;
	logic signed [PW-1:0] p_q, ip_q;
	logic signed [CW-1:0] upper_q, lower_q, cand_q;
	logic [PERW-1:0] div_rem_q;
	logic [PW-1:0] div_quo_q;
	logic div_neg_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic signed [SW-1:0] sum_q;
	logic signed [DATA_WIDTH-1:0] drive_q;
	logic m_valid_q;

	logic signed [DATA_WIDTH-1:0] sp_in, meas_in;
	logic in_beat, out_load;
	logic signed [GW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_prod;
	logic [PERW-1:0] per_eff;
	logic [PERW:0] div_shift, div_diff;
	logic div_ge;
	logic signed [CW-1:0] omax_s, omin_s, p_c, integ_c, integ_sel;
	logic signed [IW-1:0] integ_sat;
	logic signed [SW-1:0] d_ext, y_full, y_hi, y_clamp;

	assign sp_in = s_tdata[DATA_WIDTH-1:0];
	assign meas_in = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign s_tready = (state_q == pcdc_pkg::ST_IDLE);
	assign in_beat = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_valid_q;
	assign out_load = (state_q == pcdc_pkg::ST_OUT) && (!m_valid_q || m_tready);

	always_comb begin
		m_tdata = '0;
		m_tdata[DATA_WIDTH-1:0] = drive_q;
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			pcdc_pkg::ST_MUL_I: begin
				mul_a = ki_q;
				mul_b = BW'(err_q) + BW'(prev_error_q);
			end
			pcdc_pkg::ST_MUL_D: begin
				mul_a = kd_q;
				mul_b = BW'(dmeas_q);
			end
			default: begin
				mul_a = kp_q;
				mul_b = BW'(err_q);
			end
		endcase
	end
	assign mul_prod = mul_a * mul_b;

	// restoring divider step
	assign per_eff = (period_q == '0) ? pcdc_pkg::PERIOD_ONE : period_q;
	assign div_shift = {div_rem_q, div_quo_q[PW-1]};
	assign div_diff = div_shift - {1'b0, per_eff};
	assign div_ge = (div_shift >= {1'b0, per_eff});

	// integrator limits and saturation
	assign omax_s = CW'(out_max_q) <<< GAIN_FRAC_BITS;
	assign omin_s = CW'(out_min_q) <<< GAIN_FRAC_BITS;
	assign p_c = CW'(p_q);
	assign integ_c = CW'(integ_q);

	always_comb begin
		priority if (integ_c > upper_q) begin
			integ_sel = upper_q;
		end else if (integ_c < lower_q) begin
			integ_sel = lower_q;
		end else begin
			integ_sel = cand_q;
		end
		priority if (integ_sel > INT_MAX_C) begin
			integ_sat = INT_MAX_C[IW-1:0];
		end else if (integ_sel < INT_MIN_C) begin
			integ_sat = INT_MIN_C[IW-1:0];
		end else begin
			integ_sat = integ_sel[IW-1:0];
		end
	end

	// derivative sign restore, output shift and clamp
	always_comb begin
		d_ext = SW'({1'b0, div_quo_q});
		if (div_neg_q) begin
			d_ext = -d_ext;
		end
		y_full = sum_q >>> GAIN_FRAC_BITS;
		y_hi = (SW'(out_max_q) < y_full) ? SW'(out_max_q) : y_full;
		y_clamp = (SW'(out_min_q) > y_hi) ? SW'(out_min_q) : y_hi;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcdc_pkg::ST_IDLE: begin
				if (in_beat) begin
					state_d = pcdc_pkg::ST_MUL_P;
				end
			end
			pcdc_pkg::ST_MUL_P: state_d = pcdc_pkg::ST_MUL_I;
			pcdc_pkg::ST_MUL_I: state_d = pcdc_pkg::ST_LIMIT;
			pcdc_pkg::ST_LIMIT: state_d = pcdc_pkg::ST_INTEG;
			pcdc_pkg::ST_INTEG: state_d = pcdc_pkg::ST_MUL_D;
			pcdc_pkg::ST_MUL_D: state_d = pcdc_pkg::ST_DIV;
			pcdc_pkg::ST_DIV: begin
				if (div_cnt_q == CNT_W'(PW - 1)) begin
					state_d = pcdc_pkg::ST_SUM;
				end
			end
			pcdc_pkg::ST_SUM: state_d = pcdc_pkg::ST_OUT;
			pcdc_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = pcdc_pkg::ST_IDLE;
				end
			end
			default: state_d = pcdc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcdc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control, configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= pcdc_pkg::KP_RESET;
			ki_q <= '0;
			kd_q <= '0;
			out_min_q <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
			out_max_q <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
			period_q <= pcdc_pkg::PERIOD_ONE;
			integ_q <= '0;
			prev_error_q <= '0;
			prev_meas_q <= '0;
			div_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					pcdc_pkg::REG_KP: kp_q <= cfg_data[GW-1:0];
					pcdc_pkg::REG_KI: ki_q <= cfg_data[GW-1:0];
					pcdc_pkg::REG_KD: kd_q <= cfg_data[GW-1:0];
					pcdc_pkg::REG_OUT_MIN: out_min_q <= cfg_data[DATA_WIDTH-1:0];
					pcdc_pkg::REG_OUT_MAX: out_max_q <= cfg_data[DATA_WIDTH-1:0];
					pcdc_pkg::REG_SAMPLE_PERIOD: period_q <= cfg_data[PERW-1:0];
					default: ;
				endcase
			end
			if (in_beat) begin
				prev_meas_q <= meas_in;
			end
			if (state_q == pcdc_pkg::ST_MUL_I) begin
				prev_error_q <= err_q;
			end
			if (state_q == pcdc_pkg::ST_INTEG) begin
				integ_q <= integ_sat;
			end
			if (state_q == pcdc_pkg::ST_MUL_D) begin
				div_cnt_q <= '0;
			end else if (state_q == pcdc_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			err_q <= EW'(sp_in) - EW'(meas_in);
			dmeas_q <= EW'(meas_in) - EW'(prev_meas_q);
		end
		if (state_q == pcdc_pkg::ST_MUL_P) begin
			p_q <= mul_prod;
		end
		if (state_q == pcdc_pkg::ST_MUL_I) begin
			ip_q <= mul_prod;
		end
		if (state_q == pcdc_pkg::ST_LIMIT) begin
			upper_q <= (omax_s > p_c) ? omax_s - p_c : '0;
			lower_q <= (omin_s < p_c) ? omin_s - p_c : '0;
			cand_q <= integ_c + CW'(ip_q);
		end
		if (state_q == pcdc_pkg::ST_MUL_D) begin
			div_neg_q <= mul_prod[PW-1];
			div_quo_q <= mul_prod[PW-1] ? PW'(-mul_prod) : PW'(mul_prod);
			div_rem_q <= '0;
		end else if (state_q == pcdc_pkg::ST_DIV) begin
			div_rem_q <= div_ge ? div_diff[PERW-1:0] : div_shift[PERW-1:0];
			div_quo_q <= {div_quo_q[PW-2:0], div_ge};
		end
		if (state_q == pcdc_pkg::ST_SUM) begin
			sum_q <= SW'(p_q) + SW'(integ_q) + d_ext;
		end
		if (out_load) begin
			drive_q <= y_clamp[DATA_WIDTH-1:0];
		end
	end

`ifndef SYNTHESIS
	a_beat_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == pcdc_pkg::ST_MUL_P)
		else $error("accepted beat did not start the sequencer");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcdc_pkg::ST_DIV |-> div_cnt_q < CNT_W'(PW))
		else $error("divider step count overran");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcdc_pkg::ST_DIV |-> div_rem_q < per_eff)
		else $error("divider remainder not below divisor");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == pcdc_pkg::ST_OUT))
		else $error("output valid raised outside the output step");

	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (out_min_q <= out_max_q) |->
			(drive_q >= out_min_q) && (drive_q <= out_max_q))
		else $error("drive outside configured limits");
`endif

endmodule

>>> verif/pid_controller_dynamic_clamp_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for pid_controller_dynamic_clamp_top: directed and random samples
// over several gain and limit settings, predicted drive checked beat by beat
// depends on pcdc_pkg and the top level only
module pid_controller_dynamic_clamp_top_tb;

	localparam int DW = 16;
	localparam int FRAC = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 60;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 123;
	localparam longint INTEG_HI = 64'sd549755813887;
	localparam longint INTEG_LO = -64'sd549755813888;

	class drive_scoreboard;
		logic signed [15:0] kp, ki, kd;
		logic signed [DW-1:0] out_min, out_max;
		logic [15:0] period;
		longint integ, prev_err, prev_meas;
		logic [DW-1:0] expected_drive[$];
		int errors;

		function new();
			kp = pcdc_pkg::KP_RESET;
			ki = '0;
			kd = '0;
			out_min = {1'b1, {(DW-1){1'b0}}};
			out_max = {1'b0, {(DW-1){1'b1}}};
			period = pcdc_pkg::PERIOD_ONE;
			integ = 0;
			prev_err = 0;
			prev_meas = 0;
			errors = 0;
		endfunction

		function longint sat_integ(longint v);
			if (v > INTEG_HI)
				return INTEG_HI;
			if (v < INTEG_LO)
				return INTEG_LO;
			return v;
		endfunction

		function void note_config(logic [pcdc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				pcdc_pkg::REG_KP: kp = val;
				pcdc_pkg::REG_KI: ki = val;
				pcdc_pkg::REG_KD: kd = val;
				pcdc_pkg::REG_OUT_MIN: out_min = val;
				pcdc_pkg::REG_OUT_MAX: out_max = val;
				pcdc_pkg::REG_SAMPLE_PERIOD: period = val;
				default: ;
			endcase
		endfunction

		function void note_sample(logic signed [DW-1:0] sp, logic signed [DW-1:0] meas);
			longint sp_l, meas_l, err, p, omax_l, omin_l, upper, lower, per, d, y;
			sp_l = longint'(sp);
			meas_l = longint'(meas);
			omax_l = longint'(out_max);
			omin_l = longint'(out_min);
			err = sp_l - meas_l;
			p = longint'(kp) * err;
			upper = ((omax_l <<< FRAC) > p) ? (omax_l <<< FRAC) - p : 0;
			lower = ((omin_l <<< FRAC) < p) ? (omin_l <<< FRAC) - p : 0;
			if (integ > upper)
				integ = sat_integ(upper);
			else if (integ < lower)
				integ = sat_integ(lower);
			else
				integ = sat_integ(integ + longint'(ki) * (err + prev_err));
			// zero period divides by one
			per = (period == 0) ? 64'sd1 : longint'(period);
			d = (longint'(kd) * (meas_l - prev_meas)) / per;
			y = (p + integ + d) >>> FRAC;
			// crossed limits end on out_min
			if (omax_l < y)
				y = omax_l;
			if (omin_l > y)
				y = omin_l;
			prev_err = err;
			prev_meas = meas_l;
			expected_drive.push_back(y[DW-1:0]);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_drive(logic [DW-1:0] got);
			logic [DW-1:0] want;
			if (expected_drive.size() == 0) begin
				report($sformatf("drive %0d with no sample pending", $signed(got)));
			end else begin
				want = expected_drive.pop_front();
				if (got !== want)
					report($sformatf("drive %0d, expected %0d", $signed(got), $signed(want)));
			end
		endtask

		function int pending();
			return expected_drive.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// setpoint, measurement
	logic [2*DW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// drive
	logic [DW-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pcdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	drive_scoreboard sb;
	bit no_idle = 1'b0;
	int idle_cycles = 0;
	int sp_w = 0;
	int meas_w = 0;

	pid_controller_dynamic_clamp_top #(
		.DATA_WIDTH(DW),
		.GAIN_FRAC_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_drive(m_tdata);
		m_tready <= no_idle || ($urandom_range(99) >= 26);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// valid stays high after a beat; the next call or end_stream decides in the same step
	task automatic send_sample(input logic signed [DW-1:0] sp, input logic signed [DW-1:0] meas);
		if (!no_idle && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {meas, sp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(sp, meas);
	endtask

	task automatic end_stream();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [pcdc_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_config(idx, val);
	endtask

	task automatic write_settings(input logic [15:0] kp, input logic [15:0] ki,
			input logic [15:0] kd, input logic [15:0] omin, input logic [15:0] omax,
			input logic [15:0] per);
		write_reg(pcdc_pkg::REG_KP, kp);
		write_reg(pcdc_pkg::REG_KI, ki);
		write_reg(pcdc_pkg::REG_KD, kd);
		write_reg(pcdc_pkg::REG_OUT_MIN, omin);
		write_reg(pcdc_pkg::REG_OUT_MAX, omax);
		write_reg(pcdc_pkg::REG_SAMPLE_PERIOD, per);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] random_gain();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4: return 16'(int'($urandom_range(1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_settings();
		logic signed [15:0] a, b, t;
		logic [15:0] per;
		case ($urandom_range(3))
			0: begin
				a = 16'($urandom);
				b = 16'($urandom);
			end
			default: begin
				a = 16'(int'($urandom_range(4000)) - 2000);
				b = 16'(int'($urandom_range(4000)) - 2000);
			end
		endcase
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		case ($urandom_range(9))
			0: begin
				a = 16'h8000;
				b = 16'h7fff;
			end
			1: begin
				t = a;
				a = b;
				b = t;
			end
			2: b = a;
			default: ;
		endcase
		case ($urandom_range(7))
			0: per = 16'd0;
			1: per = 16'hffff;
			2: per = 16'($urandom);
			default: per = 16'($urandom_range(1, 8));
		endcase
		write_settings(random_gain(), random_gain(), random_gain(), a, b, per);
	endtask

	// mostly a measurement that tracks the setpoint, some full-range noise
	task automatic random_sample();
		logic signed [15:0] r;
		int step;
		if ($urandom_range(99) < 25) begin
			send_sample(16'($urandom), 16'($urandom));
		end else begin
			if ($urandom_range(9) == 0) begin
				r = 16'($urandom);
				sp_w = int'(r);
			end
			step = (sp_w - meas_w) / int'($urandom_range(1, 8)) + int'($urandom_range(64)) - 32;
			meas_w = meas_w + step;
			if (meas_w > 32767)
				meas_w = 32767;
			if (meas_w < -32768)
				meas_w = -32768;
			send_sample(16'(sp_w), 16'(meas_w));
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd100, 16'sd50);
		send_sample(-16'sd5, -16'sd5);
		end_stream();
		wait_drained();

		write_settings(16'h8000, 16'h7fff, 16'h8000, 16'(-1000), 16'd1000, 16'd0);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1000, -16'sd1000);
		end_stream();
		wait_drained();

		write_settings(16'h7fff, 16'h8000, 16'h7fff, 16'd500, 16'(-500), 16'hffff);
		send_sample(16'sd10, 16'sd0);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd1, 16'sd1);
		end_stream();
		wait_drained();

		write_settings(16'd384, 16'd20, 16'(-128), 16'h8000, 16'h7fff, 16'd3);
		send_sample(16'sd1000, 16'sd0);
		send_sample(16'sd1000, 16'sd200);
		send_sample(16'sd1000, 16'sd600);
		send_sample(16'sd1000, 16'sd900);
		send_sample(16'sd1000, 16'sd1100);
		send_sample(-16'sd200, 16'sd1100);
		end_stream();
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_settings();
			no_idle = (ph == 4);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_sample();
			end_stream();
			wait_drained();
			no_idle = 1'b0;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
hdl/pcdc_pkg.sv
hdl/pid_controller_dynamic_clamp_top.sv
verif/pid_controller_dynamic_clamp_top_tb.sv
